// ===== hdl/pol_pkg.sv =====
package pol_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);

	localparam logic [2:0] CMD_INS_FRONT = 3'd0;
	localparam logic [2:0] CMD_INS_BACK  = 3'd1;
	localparam logic [2:0] CMD_INS_AT    = 3'd2;
	localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
	localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
	localparam logic [2:0] CMD_DEL_AT    = 3'd5;
	localparam logic [2:0] CMD_DUMP      = 3'd6;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [2:0]          command;
		logic signed [31:0]  value;
		logic [6:0]          position;
	} req_word_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [6:0]          entry_count;
		logic signed [31:0]  element_value;
		logic [6:0]          element_index;
		logic                last;
	} rsp_word_t;

	typedef struct packed {
		logic edit;
		logic dump_start;
		logic dump_step;
	} pol_cmd_t;

	typedef struct packed {
		logic nonempty;
		logic dump_last;
	} pol_stat_t;

endpackage

// ===== hdl/pol_dpath.sv =====
module pol_dpath import pol_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  req_word_t req,
	input  pol_cmd_t  cmd,
	output pol_stat_t stat,
	output rsp_word_t rsp
);

	logic signed [31:0] cells_q [CAPACITY];
	logic signed [31:0] cells_nxt [CAPACITY];
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_nxt;
	logic [IDX_W-1:0]   idx_q;
	logic [6:0]         cnt7;
	logic [6:0]         slot7;
	logic [IDX_W-1:0]   slot;
	logic [1:0]         status;
	logic               ins;
	logic               del;
	logic               full;
	logic               empty;
	rsp_word_t          rsp_q;

	assign cnt7  = 7'(count_q);
	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);
	assign slot  = slot7[IDX_W-1:0];

	always_comb begin
		status = ST_OK;
		ins    = 1'b0;
		del    = 1'b0;
		slot7  = '0;
		unique case (req.command)
			CMD_INS_FRONT: begin
				if (full) status = ST_FULL;
				else ins = 1'b1;
			end
			CMD_INS_BACK: begin
				if (full) status = ST_FULL;
				else begin
					ins   = 1'b1;
					slot7 = cnt7;
				end
			end
			CMD_INS_AT: begin
				if (full) status = ST_FULL;
				else if (req.position == '0 || req.position > cnt7 + 7'd1) status = ST_BADPOS;
				else begin
					ins   = 1'b1;
					slot7 = req.position - 7'd1;
				end
			end
			CMD_DEL_FRONT: begin
				if (empty) status = ST_EMPTY;
				else del = 1'b1;
			end
			CMD_DEL_BACK: begin
				if (empty) status = ST_EMPTY;
				else begin
					del   = 1'b1;
					slot7 = cnt7 - 7'd1;
				end
			end
			CMD_DEL_AT: begin
				if (empty) status = ST_EMPTY;
				else if (req.position == '0 || req.position > cnt7) status = ST_BADPOS;
				else begin
					del   = 1'b1;
					slot7 = req.position - 7'd1;
				end
			end
			CMD_DUMP: begin
				if (empty) status = ST_EMPTY;
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (ins) count_nxt = count_q + CNT_W'(1);
		else if (del) count_nxt = count_q - CNT_W'(1);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] prev_v;
		logic signed [31:0] next_v;
		if (i == 0) begin : g_first
			assign prev_v = cells_q[i];
		end else begin : g_mid
			assign prev_v = cells_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_v = cells_q[i];
		end else begin : g_inner
			assign next_v = cells_q[i+1];
		end
		always_comb begin
			cells_nxt[i] = cells_q[i];
			if (ins) begin
				if (slot == IDX_W'(i)) cells_nxt[i] = req.value;
				else if (slot < IDX_W'(i)) cells_nxt[i] = prev_v;
			end else if (del) begin
				if (slot <= IDX_W'(i)) cells_nxt[i] = next_v;
			end
		end
		always_ff @(posedge clk) begin
			if (cmd.edit) cells_q[i] <= cells_nxt[i];
		end
	end

	assign stat.nonempty  = !empty;
	assign stat.dump_last = (7'(idx_q) + 7'd1 == cnt7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.edit) count_q <= count_nxt;
			if (cmd.dump_start) idx_q <= '0;
			else if (cmd.dump_step) idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.edit) begin
			rsp_q.status        <= status;
			rsp_q.entry_count   <= 7'(count_nxt);
			rsp_q.element_value <= '0;
			rsp_q.element_index <= '0;
			rsp_q.last          <= 1'b1;
		end else if (cmd.dump_step) begin
			rsp_q.status        <= ST_OK;
			rsp_q.entry_count   <= cnt7;
			rsp_q.element_value <= cells_q[idx_q];
			rsp_q.element_index <= 7'(idx_q) + 7'd1;
			rsp_q.last          <= stat.dump_last;
		end
	end

	assign rsp = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("held count beyond capacity");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.edit && full && (req.command == CMD_INS_FRONT ||
			req.command == CMD_INS_BACK || req.command == CMD_INS_AT)) |=> $stable(count_q))
		else $error("insert on full list changed count");

	a_dump_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dump_start |=> (idx_q == '0))
		else $error("dump index not cleared");

endmodule

// ===== hdl/pol_ctrl.sv =====
module pol_ctrl import pol_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic [2:0] req_command,
	output logic      req_stall,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	input  pol_stat_t stat,
	output pol_cmd_t  cmd
);

	typedef enum logic {
		IDLE,
		DUMP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   take;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != IDLE) || !out_free;
	assign take      = req_valid && !req_stall;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE: begin
				if (take) begin
					if (req_command == CMD_DUMP && stat.nonempty) cmd.dump_start = 1'b1;
					else cmd.edit = 1'b1;
				end
			end
			DUMP: begin
				if (out_free) cmd.dump_step = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.edit || cmd.dump_step) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (cmd.dump_start) state_q <= DUMP;
				end
				DUMP: begin
					if (cmd.dump_step && stat.dump_last) state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	a_dump_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DUMP) |-> req_stall)
		else $error("word taken during dump");

	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.dump_step && stat.dump_last) |=> (state_q == IDLE && out_valid_q))
		else $error("dump did not finish cleanly");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.edit, cmd.dump_start, cmd.dump_step}))
		else $error("conflicting datapath commands");

endmodule

// ===== hdl/positional_ordered_list_top.sv =====
// Channel   Direction  Word        Handshake
// req       in         req_word_t  req_valid / req_stall
// rsp       out        rsp_word_t  rsp_valid / rsp_stall
//
// An edit gives one word from the output register.
// A dump of N entries gives N words, one per cycle unless rsp_stall holds them, read from the cell row;
// no new request is taken until the last of them is loaded.
// arst_n clears the count, the controller state and the output valid.
// A stalled output holds its word; a request is taken while it drains.
module positional_ordered_list_top import pol_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	pol_cmd_t  cmd;
	pol_stat_t stat;

	pol_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_command (req.command),
		.req_stall   (req_stall),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.stat        (stat),
		.cmd         (cmd)
	);

	pol_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
